>>> rtl/core/ptu_pkg.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: shared package
// Widths, register indexes, request and response structures and helpers
// used across the threshold update block.
// ----------------------------------------------------------------------------
package ptu_pkg;

  // Number of Euler sub-steps per time step.
  localparam int SUB_STEPS = 11;
  localparam int SUB_W     = (SUB_STEPS > 1) ? $clog2(SUB_STEPS) : 1;

  // Field widths.
  localparam int DENS_W   = 48;
  localparam int SUM_W    = DENS_W + 1;
  localparam int COEF_W   = 64;
  localparam int PROB_W   = 33;
  localparam int WIDE_W   = 128;
  localparam int HALF_W   = COEF_W / 2;
  localparam int DPROD_W  = 2 * SUM_W;
  localparam int MAG_LO   = 40;
  localparam int MAG_W    = DENS_W + COEF_W - MAG_LO;
  localparam int NUM_SH   = 8;
  localparam int PROB_SH  = 32;

  // Configuration port.
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_INIT    = 3'd1;
  localparam logic [2:0] REG_YSTAR1  = 3'd2;
  localparam logic [2:0] REG_YSTAR2  = 3'd3;
  localparam logic [2:0] REG_GROWTH  = 3'd4;
  localparam logic [2:0] REG_DECAY   = 3'd5;

  localparam logic       MODE_PROB   = 1'b0;

  localparam logic [PROB_W-1:0] ONE_Q32 = {1'b1, {(PROB_W-1){1'b0}}};
  localparam logic [DENS_W-1:0] MAX_THR = {DENS_W{1'b1}};

  typedef struct packed {
    logic              mode;
    logic [DENS_W-1:0] initial_threshold;
    logic [DENS_W-1:0] critical_density_one;
    logic [DENS_W-1:0] critical_threshold_two;
    logic [COEF_W-1:0] growth_coefficient;
    logic [COEF_W-1:0] decay_coefficient;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [COEF_W-1:0] opa;
    logic [COEF_W-1:0] opb;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] quot;
  } div_rsp_t;

  // Clamp a wide unsigned value to the threshold range.
  function automatic logic [DENS_W-1:0] sat_thr(input logic [WIDE_W-1:0] x);
    logic [DENS_W-1:0] r;
    if (x[WIDE_W-1:DENS_W] != '0) begin
      r = MAX_THR;
    end else begin
      r = x[DENS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ptu_stream_if.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: stream interfaces
// Valid/ready channels for the time-step items and for the results.
// ----------------------------------------------------------------------------
interface ptu_in_if import ptu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              restart;
  logic [DENS_W-1:0] peak_density;
  logic [DENS_W-1:0] total_density;

  modport source (output valid, restart, peak_density, total_density, input ready);
  modport sink (input valid, restart, peak_density, total_density, output ready);
endinterface

interface ptu_out_if import ptu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] episode_probability;
  logic [DENS_W-1:0] threshold_value;
  logic              divide_fault;

  modport source (output valid, episode_probability, threshold_value, divide_fault,
                  input ready);
  modport sink (input valid, episode_probability, threshold_value, divide_fault,
                output ready);
endinterface

>>> rtl/core/pyrogenic_threshold_update.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update
// Updates a stored pyrogenic threshold once per time step and reports the
// episode probability or threshold comparison.
// ----------------------------------------------------------------------------
// The block accepts no new item until a time step has finished. Each of the
// 11 Euler sub-steps runs three products on the shared 64 x 64 multiplier and
// one quotient on the shared bit-serial divider (after a zero divisor only the
// decay product), and probability mode adds a final division unless the step
// faults. A finished result waits in the output register, so the next item
// may be accepted before it is taken. Configuration may only be written
// while no item is in flight.
module pyrogenic_threshold_update import ptu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  ptu_in_if.sink            item,
  ptu_out_if.source         result
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DEN_GO    = 9'b000000010,
    S_DEN_WAIT  = 9'b000000100,
    S_NUM_WAIT  = 9'b000001000,
    S_DIV_WAIT  = 9'b000010000,
    S_DEC_WAIT  = 9'b000100000,
    S_FIN       = 9'b001000000,
    S_FDIV_WAIT = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t             state;
  logic [DENS_W-1:0]  thr;
  logic [DENS_W-1:0]  peak;
  logic [DENS_W-1:0]  dens;
  logic [DPROD_W-1:0] den;
  logic [WIDE_W-1:0]  base;
  logic [SUB_W-1:0]   sub_cnt;
  logic               fault;
  logic [PROB_W-1:0]  prob;
  logic               res_valid;
  logic [PROB_W-1:0]  res_prob;
  logic [DENS_W-1:0]  res_thr;
  logic               res_fault;

  logic               decay_neg;
  logic [COEF_W-1:0]  decay_mag;
  logic [SUM_W-1:0]   sum_y1;
  logic [SUM_W-1:0]   sum_y2;
  logic [SUM_W-1:0]   fin_den;
  logic               den_zero;
  logic [WIDE_W-1:0]  mag;
  logic [WIDE_W-1:0]  up_sum;
  logic [WIDE_W:0]    up_dif;
  logic [DENS_W-1:0]  thr_upd;
  logic               fin_fault;
  logic               accept;

  ptu_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptu_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  ptu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Operand preparation.
  assign accept    = item.valid && item.ready;
  assign decay_neg = cfg.decay_coefficient[COEF_W-1];
  assign decay_mag = decay_neg ? (~cfg.decay_coefficient + 1'b1) : cfg.decay_coefficient;
  assign sum_y1    = {1'b0, cfg.critical_density_one} + {1'b0, dens};
  assign sum_y2    = {1'b0, cfg.critical_threshold_two} + {1'b0, thr};
  assign fin_den   = {1'b0, peak} + {1'b0, thr};
  assign den_zero  = (mul_rsp.prod == '0);
  assign fin_fault = fault || (cfg.mode == MODE_PROB && fin_den == '0);

  // Sub-step update from the decay product, with saturation.
  assign mag     = WIDE_W'(mul_rsp.prod[MAG_LO +: MAG_W]);
  assign up_sum  = base + mag;
  assign up_dif  = {1'b0, base} - {1'b0, mag};
  assign thr_upd = decay_neg ? (up_dif[WIDE_W] ? '0 : sat_thr(up_dif[WIDE_W-1:0]))
                             : sat_thr(up_sum);

  // Requests to the shared multiplier.
  always_comb begin
    mul_req = '0;
    case (state)
      S_DEN_GO: begin
        mul_req.start = 1'b1;
        mul_req.opa   = COEF_W'(sum_y1);
        mul_req.opb   = COEF_W'(sum_y2);
      end
      S_DEN_WAIT: begin
        mul_req.start = mul_rsp.done;
        if (den_zero) begin
          mul_req.opa = decay_mag;
          mul_req.opb = COEF_W'(thr);
        end else begin
          mul_req.opa = COEF_W'(dens);
          mul_req.opb = cfg.growth_coefficient;
        end
      end
      S_DIV_WAIT: begin
        mul_req.start = div_rsp.done;
        mul_req.opa   = decay_mag;
        mul_req.opb   = COEF_W'(thr);
      end
      default: ;
    endcase
  end

  // Requests to the shared divider.
  always_comb begin
    div_req = '0;
    case (state)
      S_NUM_WAIT: begin
        div_req.start = mul_rsp.done;
        div_req.num   = {mul_rsp.prod[WIDE_W-NUM_SH-1:0], {NUM_SH{1'b0}}};
        div_req.den   = WIDE_W'(den);
      end
      S_FIN: begin
        div_req.start = !fin_fault && cfg.mode == MODE_PROB;
        div_req.num   = WIDE_W'({peak, {PROB_SH{1'b0}}});
        div_req.den   = WIDE_W'(fin_den);
      end
      default: ;
    endcase
  end

  // Sequencer and threshold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      thr     <= '0;
      sub_cnt <= '0;
      fault   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.restart) begin
              thr <= cfg.initial_threshold;
            end
            sub_cnt <= '0;
            fault   <= 1'b0;
            state   <= S_DEN_GO;
          end
        end
        S_DEN_GO: begin
          state <= S_DEN_WAIT;
        end
        S_DEN_WAIT: begin
          if (mul_rsp.done) begin
            if (den_zero) begin
              fault <= 1'b1;
              state <= S_DEC_WAIT;
            end else begin
              state <= S_NUM_WAIT;
            end
          end
        end
        S_NUM_WAIT: begin
          if (mul_rsp.done) begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state <= S_DEC_WAIT;
          end
        end
        S_DEC_WAIT: begin
          if (mul_rsp.done) begin
            thr     <= thr_upd;
            sub_cnt <= sub_cnt + 1'b1;
            state   <= (sub_cnt == SUB_W'(SUB_STEPS - 1)) ? S_FIN : S_DEN_GO;
          end
        end
        S_FIN: begin
          fault <= fin_fault;
          state <= div_req.start ? S_FDIV_WAIT : S_DONE;
        end
        S_FDIV_WAIT: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload and intermediate values.
  always_ff @(posedge clk) begin
    if (accept) begin
      peak <= item.peak_density;
      dens <= item.total_density;
    end
    if (state == S_DEN_WAIT && mul_rsp.done) begin
      den <= mul_rsp.prod[DPROD_W-1:0];
      if (den_zero) begin
        base <= WIDE_W'(thr);
      end
    end
    if (state == S_DIV_WAIT && div_rsp.done) begin
      base <= WIDE_W'(thr) + div_rsp.quot;
    end
    if (state == S_FIN) begin
      if (fin_fault || cfg.mode == MODE_PROB) begin
        prob <= '0;
      end else begin
        prob <= (peak > thr) ? ONE_Q32 : '0;
      end
    end
    if (state == S_FDIV_WAIT && div_rsp.done) begin
      prob <= div_rsp.quot[PROB_W-1:0];
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || result.ready)) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || result.ready)) begin
      res_prob  <= prob;
      res_thr   <= thr;
      res_fault <= fault;
    end
  end

  assign item.ready                 = (state == S_IDLE);
  assign result.valid               = res_valid;
  assign result.episode_probability = res_prob;
  assign result.threshold_value     = res_thr;
  assign result.divide_fault        = res_fault;

  // The two shared units are never busy at the same time.
  assert property (@(posedge clk) disable iff (rst)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy together");

  // An accepted item always starts a sub-step.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DEN_GO)
    else $error("accepted item did not start a sub-step");

  // A faulted step reports zero probability.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.divide_fault) |-> result.episode_probability == '0)
    else $error("fault with nonzero probability");

  // Comparison mode reports only zero or one.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && cfg.mode != MODE_PROB) |->
      (result.episode_probability == '0 || result.episode_probability == ONE_Q32))
    else $error("comparison result neither zero nor one");

endmodule

>>> rtl/core/ptu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: configuration registers
// APB-style register file holding the mode and the model coefficients.
// ----------------------------------------------------------------------------
module ptu_cfg_regs import ptu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:   cfg.mode                   <= pwdata[0];
        REG_INIT:   cfg.initial_threshold      <= pwdata[DENS_W-1:0];
        REG_YSTAR1: cfg.critical_density_one   <= pwdata[DENS_W-1:0];
        REG_YSTAR2: cfg.critical_threshold_two <= pwdata[DENS_W-1:0];
        REG_GROWTH: cfg.growth_coefficient     <= pwdata;
        REG_DECAY:  cfg.decay_coefficient      <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      REG_MODE:   prdata = DATA_W'(cfg.mode);
      REG_INIT:   prdata = DATA_W'(cfg.initial_threshold);
      REG_YSTAR1: prdata = DATA_W'(cfg.critical_density_one);
      REG_YSTAR2: prdata = DATA_W'(cfg.critical_threshold_two);
      REG_GROWTH: prdata = cfg.growth_coefficient;
      REG_DECAY:  prdata = cfg.decay_coefficient;
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/ptu_mul.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: shared multiplier
// 64 x 64 unsigned product built from four 32 x 32 partial products,
// one per cycle, accumulated into a 128-bit register.
// ----------------------------------------------------------------------------
module ptu_mul import ptu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [COEF_W-1:0] opa;
  logic [COEF_W-1:0] opb;
  logic [2:0]        cnt;
  logic [1:0]        pp_idx;
  logic [COEF_W-1:0] pp;
  logic [WIDE_W-1:0] acc;
  logic              busy;
  logic              done;
  logic [HALF_W-1:0] sel_a;
  logic [HALF_W-1:0] sel_b;
  logic [WIDE_W-1:0] pp_shifted;

  // Operand halves for the current partial product.
  assign sel_a = cnt[1] ? opa[COEF_W-1:HALF_W] : opa[HALF_W-1:0];
  assign sel_b = (cnt[1:0] == 2'd1 || cnt[1:0] == 2'd3) ?
                 opb[COEF_W-1:HALF_W] : opb[HALF_W-1:0];

  // Weight of the registered partial product.
  always_comb begin
    case (pp_idx)
      2'd0:    pp_shifted = WIDE_W'(pp);
      2'd3:    pp_shifted = {pp, {COEF_W{1'b0}}};
      default: pp_shifted = WIDE_W'(pp) << HALF_W;
    endcase
  end

  // Multiply in one cycle, accumulate in the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      opa <= req.opa;
      opb <= req.opb;
      acc <= '0;
    end else if (busy) begin
      pp     <= sel_a * sel_b;
      pp_idx <= cnt[1:0];
      if (cnt != 3'd0) begin
        acc <= acc + pp_shifted;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

>>> rtl/core/ptu_div.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: shared divider
// Restoring 128 / 128 unsigned divider producing one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ptu_div import ptu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(WIDE_W);

  logic [WIDE_W-1:0] num;
  logic [WIDE_W-1:0] den;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [WIDE_W-1:0] trial;
  logic              ge;

  // One restoring step: bring in the next numerator bit and try to subtract.
  assign trial = {rem[WIDE_W-2:0], num[WIDE_W-1]};
  assign ge    = (trial >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDE_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[WIDE_W-2:0], 1'b0};
      rem  <= ge ? (trial - den) : trial;
      quot <= {quot[WIDE_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Pyrogenic threshold update: testbench
// Drives time-step items and register writes into the block, predicts every
// result with an independent fixed-point model of the threshold update and
// compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ptu_pkg::*;

  localparam int  LIMIT_CYCLES = 12_000_000;
  localparam int  RAND_PHASES  = 8;
  localparam int  PHASE_ITEMS  = 125;
  localparam int  LONG_HOLD    = 8000;

  // One time step offered to the block.
  typedef struct {
    logic              restart;
    logic [DENS_W-1:0] peak;
    logic [DENS_W-1:0] total;
  } step_t;

  // One result of a time step.
  typedef struct {
    logic [PROB_W-1:0] prob;
    logic [DENS_W-1:0] thr;
    logic              fault;
  } outcome_t;

  // Directed row: the expected outcome is typed in only where checked is set.
  typedef struct {
    step_t    stim;
    logic     checked;
    outcome_t want;
  } row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ptu_in_if  step_if ();
  ptu_out_if res_if ();

  pyrogenic_threshold_update i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (step_if.sink),
    .result  (res_if.source)
  );

  // Shadow of the configuration and of the stored threshold.
  cfg_t              shadow_cfg;
  logic [DENS_W-1:0] shadow_thr;

  outcome_t pending_outcomes[$];
  outcome_t typed_outcomes[$];
  bit       typed_flags[$];

  int  fail_count;
  int  steps_sent;
  int  results_seen;
  int  faults_seen;
  int  restarts_sent;
  int  cycle_count;
  int  hold_left;
  bit  no_idle;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** pyrogenic_threshold_update: FAILED **");
      $finish;
    end
  end

  // Result acceptance: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 8);
    end
  end

  function automatic logic [DENS_W-1:0] sat_clamp(input logic [127:0] x);
    return (x > 128'(MAX_THR)) ? MAX_THR : x[DENS_W-1:0];
  endfunction

  // One Euler sub-step of the threshold; returns 1 on a zero divisor.
  function automatic bit euler_substep(input logic [DENS_W-1:0] dens);
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] inc;
    logic [127:0] mag;
    logic [127:0] base;
    logic [63:0]  bmag;
    logic [48:0]  sum_a;
    logic [48:0]  sum_b;
    bit           fault;
    fault = 1'b0;
    inc   = '0;
    sum_a = {1'b0, shadow_cfg.critical_density_one} + {1'b0, dens};
    sum_b = {1'b0, shadow_cfg.critical_threshold_two} + {1'b0, shadow_thr};
    den   = 128'(sum_a) * 128'(sum_b);
    if (den == '0) begin
      fault = 1'b1;
    end else begin
      num = 128'(dens) * 128'(shadow_cfg.growth_coefficient);
      num = num << NUM_SH;
      inc = num / den;
    end
    bmag = shadow_cfg.decay_coefficient[63] ? -shadow_cfg.decay_coefficient
                                            : shadow_cfg.decay_coefficient;
    mag  = (128'(bmag) * 128'(shadow_thr)) >> MAG_LO;
    base = 128'(shadow_thr) + inc;
    if (shadow_cfg.decay_coefficient[63]) begin
      shadow_thr = (mag >= base) ? '0 : sat_clamp(base - mag);
    end else begin
      shadow_thr = sat_clamp(base + mag);
    end
    return fault;
  endfunction

  // Whole time step: restart, sub-steps, then probability or comparison.
  function automatic outcome_t threshold_step(input step_t s);
    outcome_t     o;
    logic [63:0]  d;
    logic [127:0] q;
    bit           fault;
    fault = 1'b0;
    if (s.restart) shadow_thr = shadow_cfg.initial_threshold;
    for (int k = 0; k < SUB_STEPS; k++) begin
      if (euler_substep(s.total)) fault = 1'b1;
    end
    o.prob = '0;
    if (shadow_cfg.mode == MODE_PROB) begin
      d = 64'(s.peak) + 64'(shadow_thr);
      if (d == '0) begin
        fault = 1'b1;
      end else begin
        q      = (128'(s.peak) << PROB_SH) / 128'(d);
        o.prob = q[PROB_W-1:0];
      end
    end else begin
      o.prob = (s.peak > shadow_thr) ? ONE_Q32 : '0;
    end
    if (fault) o.prob = '0;
    o.thr   = shadow_thr;
    o.fault = fault;
    return o;
  endfunction

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen <= results_seen + 1;
      if (res_if.divide_fault) faults_seen <= faults_seen + 1;
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        w = pending_outcomes.pop_front();
        if (typed_flags.pop_front()) begin
          void'(typed_outcomes.pop_front());
        end
        if (res_if.episode_probability !== w.prob) begin
          $error("episode_probability: expected %h, got %h", w.prob,
                 res_if.episode_probability);
          fail_count++;
        end
        if (res_if.threshold_value !== w.thr) begin
          $error("threshold_value: expected %h, got %h", w.thr, res_if.threshold_value);
          fail_count++;
        end
        if (res_if.divide_fault !== w.fault) begin
          $error("divide_fault: expected %b, got %b", w.fault, res_if.divide_fault);
          fail_count++;
        end
      end
    end
  end

  // Offer one time step and record its expectation on acceptance.
  task automatic send_step(input step_t s, input bit typed, input outcome_t want);
    outcome_t p;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      step_if.valid <= 1'b0;
      @(negedge clk);
    end
    step_if.valid         <= 1'b1;
    step_if.restart       <= s.restart;
    step_if.peak_density  <= s.peak;
    step_if.total_density <= s.total;
    do @(posedge clk); while (!step_if.ready);
    p = threshold_step(s);
    if (typed && p !== want) begin
      $error("directed row disagrees: expected %h/%h/%b, predicted %h/%h/%b",
             want.prob, want.thr, want.fault, p.prob, p.thr, p.fault);
      fail_count++;
    end
    pending_outcomes.push_back(typed ? want : p);
    typed_flags.push_back(typed);
    if (typed) typed_outcomes.push_back(want);
    steps_sent++;
    if (s.restart) restarts_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    step_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   shadow_cfg.mode                   = value[0];
      REG_INIT:   shadow_cfg.initial_threshold      = value[DENS_W-1:0];
      REG_YSTAR1: shadow_cfg.critical_density_one   = value[DENS_W-1:0];
      REG_YSTAR2: shadow_cfg.critical_threshold_two = value[DENS_W-1:0];
      REG_GROWTH: shadow_cfg.growth_coefficient     = value;
      REG_DECAY:  shadow_cfg.decay_coefficient      = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(REG_MODE,   64'(c.mode));
    write_reg(REG_INIT,   64'(c.initial_threshold));
    write_reg(REG_YSTAR1, 64'(c.critical_density_one));
    write_reg(REG_YSTAR2, 64'(c.critical_threshold_two));
    write_reg(REG_GROWTH, c.growth_coefficient);
    write_reg(REG_DECAY,  c.decay_coefficient);
  endtask

  // A 48-bit value spread over magnitudes, with the extremes now and then.
  function automatic logic [DENS_W-1:0] rand_q24();
    logic [DENS_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 19);
    v    = DENS_W'({$urandom(), $urandom()});
    if (pick == 0) return '0;
    if (pick == 1) return MAX_THR;
    return v >> $urandom_range(0, 47);
  endfunction

  function automatic logic [63:0] rand_coef();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v >> $urandom_range(0, 63);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   pick;
    c.mode                   = 1'($urandom_range(0, 1));
    c.initial_threshold      = rand_q24();
    c.critical_density_one   = rand_q24();
    c.critical_threshold_two = rand_q24();
    c.growth_coefficient     = ($urandom_range(0, 9) == 0) ? '1 : rand_coef();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      c.decay_coefficient = 64'h8000_0000_0000_0000;
    end else if (pick == 1) begin
      // Positive decay coefficient: the decay term adds to the threshold.
      c.decay_coefficient = rand_coef() >> 8;
    end else begin
      c.decay_coefficient = -(rand_coef() >> $urandom_range(8, 30));
    end
    return c;
  endfunction

  function automatic step_t rand_step();
    step_t s;
    s.restart = ($urandom_range(0, 9) == 0);
    s.peak    = rand_q24();
    s.total   = rand_q24();
    return s;
  endfunction

  // Directed rows under the reset configuration: every sub-step divides by
  // zero, so the threshold stays at zero and the fault is always raised.
  row_t reset_rows[6];
  // Directed rows checked against the predictor under several settings.
  step_t probe_steps[6];

  initial begin
    outcome_t all_fault;
    outcome_t none;
    cfg_t     c;
    step_t    s;
    int       n;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    step_if.valid = 1'b0;
    step_if.restart       = 1'b0;
    step_if.peak_density  = '0;
    step_if.total_density = '0;
    shadow_cfg    = '0;
    shadow_thr    = '0;
    fail_count    = 0;
    steps_sent    = 0;
    results_seen  = 0;
    faults_seen   = 0;
    restarts_sent = 0;
    cycle_count   = 0;
    hold_left     = 0;
    no_idle       = 1'b0;

    all_fault = '{prob: '0, thr: '0, fault: 1'b1};
    none      = '{prob: '0, thr: '0, fault: 1'b0};
    reset_rows[0] = '{'{1'b0, '0, '0}, 1'b1, all_fault};
    reset_rows[1] = '{'{1'b0, MAX_THR, MAX_THR}, 1'b1, all_fault};
    reset_rows[2] = '{'{1'b1, MAX_THR, '0}, 1'b1, all_fault};
    reset_rows[3] = '{'{1'b1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555}, 1'b1, all_fault};
    reset_rows[4] = '{'{1'b0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA}, 1'b1, all_fault};
    reset_rows[5] = '{'{1'b0, 48'h0000_0100_0000, MAX_THR}, 1'b1, all_fault};

    probe_steps[0] = '{1'b1, '0, '0};
    probe_steps[1] = '{1'b0, MAX_THR, MAX_THR};
    probe_steps[2] = '{1'b0, 48'h0000_0200_0000, 48'h0000_0100_0000};
    probe_steps[3] = '{1'b1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555};
    probe_steps[4] = '{1'b0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA};
    probe_steps[5] = '{1'b1, '0, MAX_THR};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration.
    foreach (reset_rows[i]) send_step(reset_rows[i].stim, reset_rows[i].checked,
                                      reset_rows[i].want);
    drop_valid();
    wait_drained();

    // Ordinary settings; the first restart row, with zero peak, divides by zero.
    c = '{mode: MODE_PROB, initial_threshold: '0, critical_density_one: 48'h1_000000,
          critical_threshold_two: 48'h1_000000, growth_coefficient: 64'h100_0000_0000,
          decay_coefficient: -64'h4000_0000};
    write_all(c);
    foreach (probe_steps[i]) send_step(probe_steps[i], 1'b0, none);
    drop_valid();
    wait_drained();

    // Saturation at the top: largest growth and positive decay.
    c = '{mode: 1'b1, initial_threshold: MAX_THR, critical_density_one: '0,
          critical_threshold_two: '0, growth_coefficient: '1,
          decay_coefficient: 64'h7FFF_FFFF_FFFF_FFFF};
    write_all(c);
    foreach (probe_steps[i]) send_step(probe_steps[i], 1'b0, none);
    drop_valid();
    wait_drained();

    // Saturation at zero: most negative decay.
    c.decay_coefficient  = 64'h8000_0000_0000_0000;
    c.growth_coefficient = 64'h1;
    write_reg(REG_GROWTH, c.growth_coefficient);
    write_reg(REG_DECAY,  c.decay_coefficient);
    foreach (probe_steps[i]) send_step(probe_steps[i], 1'b0, none);
    drop_valid();
    wait_drained();

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_all(rand_cfg());
      no_idle = (ph == 3);
      if (ph == 5) hold_left = LONG_HOLD;
      n = 0;
      while (n < PHASE_ITEMS) begin
        s = rand_step();
        send_step(s, 1'b0, none);
        n++;
        if (ph == 2 && n == PHASE_ITEMS / 2) begin
          // Sender holds back until every result is home.
          drop_valid();
          wait_drained();
        end
      end
      drop_valid();
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (50) @(posedge clk);
    $display("Covered %0d time steps (%0d restarts) over %0d register settings;",
             steps_sent, restarts_sent, RAND_PHASES + 4);
    $display("%0d results checked, %0d of them with a divide fault.",
             results_seen, faults_seen);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("** pyrogenic_threshold_update: PASSED **");
    end else begin
      $display("** pyrogenic_threshold_update: FAILED **");
    end
    $finish;
  end

endmodule

>>> pyrogenic_threshold_update.f
rtl/core/ptu_pkg.sv
rtl/core/ptu_stream_if.sv
rtl/core/ptu_cfg_regs.sv
rtl/core/ptu_mul.sv
rtl/core/ptu_div.sv
rtl/core/pyrogenic_threshold_update.sv
sim/tb_top.sv
